// File: rtl/ura_pkg.sv
// Types and constants shared by the ultrasonic range alarm.
// No dependencies.
package ura_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WARNING_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN_US      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_LEN_US       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_MS          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MS           = 3'd4;

    localparam logic [10:0] THRESHOLD_RESET = 11'd30;
    localparam logic [15:0] FRAME_LEN_RESET = 16'd60000;
    localparam logic [7:0]  TRIG_LEN_RESET  = 8'd10;
    localparam logic [9:0]  BLINK_RESET     = 10'd100;
    localparam logic [12:0] HOLD_RESET      = 13'd3000;

    localparam logic [16:0] DIST_RESET = 17'd100000;
    localparam logic [18:0] DUTY_OFF   = 19'd3000;
    localparam logic [7:0]  DUTY_SCALE = 8'd150;

    // distance = floor(echo * 34 / 1000) = floor(echo * 17 / 500)
    // floor(n / 500) = (n * RECIP_MULT) >> RECIP_SHIFT, exact for n < 2^21
    localparam logic [4:0]  SOUND_NUM   = 5'd17;
    localparam logic [21:0] RECIP_MULT  = 22'd2147484;
    localparam int          RECIP_SHIFT = 30;

    typedef struct packed {
        logic us_tick;
        logic ms_tick;
        logic echo_level;
        logic clear_button;
    } ura_in_t;

    typedef struct packed {
        logic        trigger_out;
        logic        led_out;
        logic        warning_flag;
        logic [16:0] distance_cm;
        logic [18:0] buzzer_duty;
    } ura_out_t;

endpackage

// File: rtl/ultrasonic_range_alarm.sv
// Ultrasonic range alarm: trigger/echo timing, distance, warning, LED and buzzer duty.
// Depends on ura_pkg.
//
// Usage:
//   in_*  : one tick item per transfer (us_tick, ms_tick, echo_level, clear_button).
//   out_* : one result per input item, in order: pin levels, warning, distance
//           and buzzer PWM compare value after that item's update.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Timing:
//   Three register stages: input register, state update, result register.
//   out_valid rises once the item has moved through the input register and
//   the state update into the result register; one item is accepted every
//   cycle unless out_ready stalls the pipeline. The state update stage holds
//   one multiply by a reciprocal constant (distance) feeding the warning compare.
// Reset:
//   Counters clear, distance reads 100000, trigger, LED and warning are low,
//   registers take their default values, and the pipeline is empty.
// Stall:
//   When out_ready is low a valid result in the result register holds; the stages
//   behind it fill and in_ready drops only when all three are occupied.
module ultrasonic_range_alarm
    import ura_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ura_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ura_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [10:0] threshold_reg;
    logic [15:0] frame_len_reg;
    logic [7:0]  trig_len_reg;
    logic [9:0]  blink_ms_reg;
    logic [12:0] hold_ms_reg;

    logic        in_valid_reg;
    ura_in_t     in_data_reg;
    logic        mid_valid_reg;
    logic        out_valid_reg;
    ura_out_t    out_data_reg;

    logic [15:0] frame_count_reg, frame_count_next;
    logic [15:0] echo_count_reg, echo_count_next;
    logic [16:0] distance_reg, distance_next;
    logic        trigger_reg, trigger_next;
    logic        warning_reg, warning_next;
    logic [9:0]  blink_count_reg, blink_count_next;
    logic [12:0] hold_count_reg, hold_count_next;
    logic        led_reg, led_next;

    logic        out_load;
    logic        mid_load;
    logic        in_load;

    logic [15:0] frame_inc;
    logic [15:0] echo_inc;
    logic [20:0] echo_scaled;
    logic [42:0] recip_prod;
    logic [9:0]  blink_inc;
    logic [12:0] hold_inc;
    logic [18:0] duty;

    assign out_load  = mid_valid_reg && (!out_valid_reg || out_ready);
    assign mid_load  = in_valid_reg && (!mid_valid_reg || out_load);
    assign in_load   = in_valid && in_ready;
    assign in_ready  = !in_valid_reg || mid_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            frame_len_reg <= FRAME_LEN_RESET;
            trig_len_reg  <= TRIG_LEN_RESET;
            blink_ms_reg  <= BLINK_RESET;
            hold_ms_reg   <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WARNING_THRESHOLD: threshold_reg <= cfg_data[10:0];
                CFG_FRAME_LEN_US:      frame_len_reg <= cfg_data;
                CFG_TRIG_LEN_US:       trig_len_reg  <= cfg_data[7:0];
                CFG_BLINK_MS:          blink_ms_reg  <= cfg_data[9:0];
                CFG_HOLD_MS:           hold_ms_reg   <= cfg_data[12:0];
                default:               ;
            endcase
        end
    end

    // Per-item state update: microsecond work first, then millisecond work.
    always_comb
    begin
        frame_count_next = frame_count_reg;
        echo_count_next  = echo_count_reg;
        distance_next    = distance_reg;
        trigger_next     = trigger_reg;
        warning_next     = warning_reg;
        blink_count_next = blink_count_reg;
        hold_count_next  = hold_count_reg;
        led_next         = led_reg;

        frame_inc   = frame_count_reg + 16'd1;
        echo_inc    = (in_data_reg.echo_level && (echo_count_reg != 16'hFFFF))
                      ? echo_count_reg + 16'd1 : echo_count_reg;
        echo_scaled = 21'(echo_inc) * 21'(SOUND_NUM);
        recip_prod  = 43'(echo_scaled) * 43'(RECIP_MULT);

        if (in_data_reg.us_tick)
        begin
            if (frame_count_reg == 16'd0)
            begin
                trigger_next = 1'b1;
            end
            else if (frame_count_reg >= 16'(trig_len_reg))
            begin
                trigger_next = 1'b0;
            end
            frame_count_next = frame_inc;
            echo_count_next  = echo_inc;
            if ((frame_inc >= frame_len_reg) || (frame_inc == 16'd0))
            begin
                distance_next    = 17'(recip_prod[42:RECIP_SHIFT]);
                echo_count_next  = 16'd0;
                frame_count_next = 16'd0;
            end
        end

        blink_inc = blink_count_reg + 10'd1;
        hold_inc  = hold_count_reg + 13'd1;

        if (in_data_reg.ms_tick)
        begin
            if (distance_next <= 17'(threshold_reg))
            begin
                warning_next = 1'b1;
            end
            if (warning_next)
            begin
                blink_count_next = blink_inc;
                if (blink_inc >= blink_ms_reg)
                begin
                    led_next         = !led_reg;
                    blink_count_next = 10'd0;
                end
            end
            if (in_data_reg.clear_button && warning_next)
            begin
                hold_count_next = hold_inc;
                if (hold_inc >= hold_ms_reg)
                begin
                    led_next         = 1'b0;
                    warning_next     = 1'b0;
                    blink_count_next = 10'd0;
                    hold_count_next  = 13'd0;
                end
            end
            else
            begin
                hold_count_next = 13'd0;
            end
        end
    end

    // Within the threshold the distance is below 2048, so 11 bits carry it.
    always_comb
    begin
        if (distance_reg <= 17'(threshold_reg))
        begin
            duty = 19'(distance_reg[10:0]) * 19'(DUTY_SCALE);
        end
        else
        begin
            duty = DUTY_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            mid_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_count_reg <= 16'd0;
            echo_count_reg  <= 16'd0;
            distance_reg    <= DIST_RESET;
            trigger_reg     <= 1'b0;
            warning_reg     <= 1'b0;
            blink_count_reg <= 10'd0;
            hold_count_reg  <= 13'd0;
            led_reg         <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (!mid_valid_reg || out_load)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= mid_valid_reg;
            end
            if (mid_load)
            begin
                frame_count_reg <= frame_count_next;
                echo_count_reg  <= echo_count_next;
                distance_reg    <= distance_next;
                trigger_reg     <= trigger_next;
                warning_reg     <= warning_next;
                blink_count_reg <= blink_count_next;
                hold_count_reg  <= hold_count_next;
                led_reg         <= led_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg.trigger_out  <= trigger_reg;
            out_data_reg.led_out      <= led_reg;
            out_data_reg.warning_flag <= warning_reg;
            out_data_reg.distance_cm  <= distance_reg;
            out_data_reg.buzzer_duty  <= duty;
        end
    end

endmodule
